>>> hdl/adlx_pkg.sv
package adlx_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 15;
    localparam int CREDITS   = 4;

    localparam logic [15:0] WEIGHT_FULL = 16'h7FFF;

    localparam logic [2:0] SEL_BYPASS = 3'd0;
    localparam logic [2:0] SEL_ONE    = 3'd1;
    localparam logic [2:0] SEL_TWO    = 3'd2;
    localparam logic [2:0] SEL_THREE  = 3'd3;
    localparam logic [2:0] SEL_FOUR   = 3'd4;

    localparam logic [2:0] REG_DELAY_ONE   = 3'd0;
    localparam logic [2:0] REG_DELAY_TWO   = 3'd1;
    localparam logic [2:0] REG_DELAY_THREE = 3'd2;
    localparam logic [2:0] REG_DELAY_FOUR  = 3'd3;
    localparam logic [2:0] REG_RAMP_STEP   = 3'd4;

    localparam logic [12:0] RST_DELAY_ONE   = 13'd1024;
    localparam logic [12:0] RST_DELAY_TWO   = 13'd2048;
    localparam logic [12:0] RST_DELAY_THREE = 13'd4096;
    localparam logic [12:0] RST_DELAY_FOUR  = 13'd8000;
    localparam logic [14:0] RST_RAMP_STEP   = 15'd1023;

    typedef enum logic [1:0] {
        SRC_RAM,
        SRC_FWD,
        SRC_ZERO
    } t_src;

    typedef struct packed {
        t_src        src;
        logic [15:0] weight;
        logic        faded;
        logic [2:0]  idx;
    } t_ctl;

    typedef struct packed {
        logic [15:0] sample;
        logic [2:0]  idx;
        logic        faded;
    } t_res;

endpackage

>>> hdl/audio_delay_line_crossfade.sv
// Audio delay line with crossfade. One sample item is taken per clock while input stall
// is low; each result passes through a registered RAM read, a registered 16x16 multiply
// and a four-entry output queue. Input stall rises only when four items are outstanding,
// so a waiting result does not hold off new items. The ring buffer has no clearing pass:
// entries not yet written since reset read as zero from the write fill state. BUFFER_DEPTH
// must be a power of two.
module audio_delay_line_crossfade
    import adlx_pkg::*;
#(
    parameter int BUFFER_DEPTH = 8192,
    parameter int BLOCK_LEN    = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_index,
    input  logic [14:0]                i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_in_sample,
    input  logic                       i_advance_delay,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_out_sample,
    output logic [2:0]                 o_delay_index,
    output logic                       o_in_transition
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(CREDITS + 1);

    logic                accept, deliver;
    logic [CW-1:0]       r_cnt;
    logic [AW-1:0]       wr_addr, rd_addr;
    t_ctl                ctl;
    logic [SAMPLE_W-1:0] rdata;
    logic                res_valid;
    t_res                res, head;

    assign o_in_stall = (r_cnt == CW'(CREDITS));
    assign accept     = i_in_valid && !o_in_stall;
    assign deliver    = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case ({accept, deliver})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    adlx_ctrl #(
        .BUFFER_DEPTH(BUFFER_DEPTH),
        .BLOCK_LEN   (BLOCK_LEN)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_advance  (i_advance_delay),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr),
        .o_ctl      (ctl)
    );

    adlx_ram #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (accept),
        .i_waddr(wr_addr),
        .i_wdata(i_in_sample),
        .i_re   (accept),
        .i_raddr(rd_addr),
        .o_rdata(rdata)
    );

    adlx_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_ctl   (ctl),
        .i_sample(i_in_sample),
        .i_rdata (rdata),
        .o_valid (res_valid),
        .o_res   (res)
    );

    adlx_ofifo u_ofifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_valid),
        .i_data (res),
        .o_valid(o_out_valid),
        .i_stall(i_out_stall),
        .o_data (head)
    );

    assign o_out_sample    = $signed(head.sample);
    assign o_delay_index   = head.idx;
    assign o_in_transition = head.faded;

endmodule

>>> hdl/adlx_ram.sv
module adlx_ram
    import adlx_pkg::*;
#(
    parameter int BUFFER_DEPTH = 8192,
    localparam int AW = $clog2(BUFFER_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic [SAMPLE_W-1:0] i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output logic [SAMPLE_W-1:0] o_rdata
);

    logic [SAMPLE_W-1:0] r_mem [BUFFER_DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/adlx_ctrl.sv
module adlx_ctrl
    import adlx_pkg::*;
#(
    parameter int BUFFER_DEPTH = 8192,
    parameter int BLOCK_LEN    = 32,
    localparam int AW = $clog2(BUFFER_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [14:0]   i_cfg_data,
    input  logic          i_accept,
    input  logic          i_advance,
    output logic [AW-1:0] o_wr_addr,
    output logic [AW-1:0] o_rd_addr,
    output t_ctl          o_ctl
);

    localparam int BPW = (2 * BLOCK_LEN > 1) ? $clog2(2 * BLOCK_LEN) : 1;
    localparam logic [BPW-1:0] BP_MID  = BPW'(BLOCK_LEN);
    localparam logic [BPW-1:0] BP_LAST = BPW'(2 * BLOCK_LEN - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_OUT,
        PH_IN
    } t_phase;

    logic [12:0]    r_delay_one, r_delay_two, r_delay_three, r_delay_four;
    logic [14:0]    r_ramp;
    logic [AW-1:0]  r_wr_idx, r_rd_idx;
    logic           r_wrapped;
    logic [BPW-1:0] r_bpos;
    logic           r_pending;
    t_phase         r_phase;
    logic [15:0]    r_weight;
    logic [2:0]     r_sel;

    logic           start, jump, last, pend0, adv_ok;
    t_phase         ph0, ph1, n_phase;
    logic [15:0]    w0, w1, n_weight;
    logic [12:0]    dly;
    logic [31:0]    dly_ext;
    logic [AW-1:0]  dly_mod, rd;
    logic [2:0]     n_sel;
    logic           n_pending;
    logic [BPW-1:0] n_bpos;
    t_src           src;

    always_comb begin
        unique case (r_sel)
            SEL_ONE:   dly = r_delay_one;
            SEL_TWO:   dly = r_delay_two;
            SEL_THREE: dly = r_delay_three;
            SEL_FOUR:  dly = r_delay_four;
            default:   dly = '0;
        endcase
        dly_ext = 32'(dly);
        dly_mod = dly_ext[AW-1:0];

        start = (r_bpos == '0) && r_pending;
        ph0   = start ? PH_OUT : r_phase;
        w0    = start ? WEIGHT_FULL : r_weight;
        jump  = (ph0 == PH_OUT) && (r_bpos == BP_MID);
        ph1   = jump ? PH_IN : ph0;
        w1    = jump ? '0 : w0;
        rd    = jump ? (r_wr_idx - dly_mod) : r_rd_idx;

        unique case (ph1)
            PH_OUT:  n_weight = w1 - {2'b00, r_ramp[14:1]};
            PH_IN:   n_weight = w1 + {1'b0, r_ramp};
            default: n_weight = w1;
        endcase

        pend0     = start ? 1'b0 : r_pending;
        adv_ok    = i_advance && !pend0 && (ph1 == PH_IDLE);
        n_sel     = r_sel;
        if (adv_ok) begin
            n_sel = (r_sel >= SEL_FOUR) ? SEL_BYPASS : r_sel + 3'd1;
        end
        n_pending = adv_ok || pend0;

        last    = (r_bpos == BP_LAST);
        n_bpos  = last ? '0 : r_bpos + 1'b1;
        n_phase = (last && ph1 == PH_IN) ? PH_IDLE : ph1;

        if (rd == r_wr_idx) begin
            src = SRC_FWD;
        end else if (r_wrapped || rd < r_wr_idx) begin
            src = SRC_RAM;
        end else begin
            src = SRC_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_one   <= RST_DELAY_ONE;
            r_delay_two   <= RST_DELAY_TWO;
            r_delay_three <= RST_DELAY_THREE;
            r_delay_four  <= RST_DELAY_FOUR;
            r_ramp        <= RST_RAMP_STEP;
            r_wr_idx      <= '0;
            r_rd_idx      <= '0;
            r_wrapped     <= 1'b0;
            r_bpos        <= '0;
            r_pending     <= 1'b1;
            r_phase       <= PH_IDLE;
            r_weight      <= '0;
            r_sel         <= SEL_FOUR;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_DELAY_ONE:   r_delay_one   <= i_cfg_data[12:0];
                    REG_DELAY_TWO:   r_delay_two   <= i_cfg_data[12:0];
                    REG_DELAY_THREE: r_delay_three <= i_cfg_data[12:0];
                    REG_DELAY_FOUR:  r_delay_four  <= i_cfg_data[12:0];
                    REG_RAMP_STEP:   r_ramp        <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_wr_idx  <= r_wr_idx + 1'b1;
                r_rd_idx  <= rd + 1'b1;
                if (r_wr_idx == '1) begin
                    r_wrapped <= 1'b1;
                end
                r_bpos    <= n_bpos;
                r_pending <= n_pending;
                r_phase   <= n_phase;
                r_weight  <= n_weight;
                r_sel     <= n_sel;
            end
        end
    end

    assign o_wr_addr    = r_wr_idx;
    assign o_rd_addr    = rd;
    assign o_ctl.src    = src;
    assign o_ctl.weight = n_weight;
    assign o_ctl.faded  = (ph1 != PH_IDLE);
    assign o_ctl.idx    = n_sel;

endmodule

>>> hdl/adlx_scale.sv
module adlx_scale
    import adlx_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  t_ctl                       i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [SAMPLE_W-1:0]        i_rdata,
    output logic                       o_valid,
    output t_res                       o_res
);

    logic                r_b_valid;
    t_ctl                r_b_ctl;
    logic [SAMPLE_W-1:0] r_b_sample;

    logic                r_c_valid;
    logic signed [31:0]  r_c_prod;
    logic [SAMPLE_W-1:0] r_c_sample;
    logic                r_c_faded;
    logic [2:0]          r_c_idx;

    logic signed [SAMPLE_W-1:0] smp;
    logic signed [31:0]         prod;

    always_comb begin
        case (r_b_ctl.src)
            SRC_FWD: smp = $signed(r_b_sample);
            SRC_RAM: smp = $signed(i_rdata);
            default: smp = '0;
        endcase
        prod = $signed(r_b_ctl.weight) * smp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_b_valid <= i_valid;
            r_c_valid <= r_b_valid;
        end
        if (i_valid) begin
            r_b_ctl    <= i_ctl;
            r_b_sample <= i_sample;
        end
        if (r_b_valid) begin
            r_c_prod   <= prod;
            r_c_sample <= smp;
            r_c_faded  <= r_b_ctl.faded;
            r_c_idx    <= r_b_ctl.idx;
        end
    end

    assign o_valid      = r_c_valid;
    assign o_res.sample = r_c_faded ? r_c_prod[FRAC_BITS +: SAMPLE_W] : r_c_sample;
    assign o_res.idx    = r_c_idx;
    assign o_res.faded  = r_c_faded;

endmodule

>>> hdl/adlx_ofifo.sv
module adlx_ofifo
    import adlx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_data
);

    localparam int PW = $clog2(CREDITS);
    localparam int CW = $clog2(CREDITS + 1);

    t_res          r_buf [CREDITS];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

endmodule

>>> hdl/adlx_chk.sv
module adlx_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_out_sample,
    input logic [2:0]  o_delay_index,
    input logic        o_in_transition
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_sample)
            && $stable(o_delay_index) && $stable(o_in_transition))
        else $error("stalled output item changed");

    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##3 o_out_valid)
        else $error("result missing three cycles after accept");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_delay_index > 3'd4 |-> 1'b0)
        else $error("delay index out of range");

endmodule

bind audio_delay_line_crossfade adlx_chk u_adlx_chk (.*);
